/* rtl/vtfp_pkg.sv */
`timescale 1ns / 1ps

package vtfp_pkg;

    localparam logic [7:0] HDR_BYTE   = 8'hAA;
    localparam logic [7:0] TYPE_DOT   = 8'h30;
    localparam logic [7:0] TYPE_CIRC  = 8'h31;
    localparam logic [7:0] TYPE_COLOR = 8'h32;
    localparam logic [7:0] TAIL_BYTE  = 8'hFF;

    localparam logic [1:0] KIND_DOT   = 2'd0;
    localparam logic [1:0] KIND_CIRC  = 2'd1;
    localparam logic [1:0] KIND_COLOR = 2'd2;

    // Frame positions of the tail byte for the two frame lengths.
    localparam logic [3:0] TAIL_POS_SHORT = 4'd7;
    localparam logic [3:0] TAIL_POS_LONG  = 4'd9;
    localparam logic [3:0] POS_HEADER     = 4'd0;
    localparam logic [3:0] POS_TYPE       = 4'd1;
    localparam logic [3:0] POS_PAYLOAD    = 4'd2;

    localparam int PAY_DEPTH   = 7;
    localparam int PAY_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        OP_STORE,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [PAY_IDX_W-1:0] idx;
        logic [7:0]           data;
        logic [1:0]           kind;
    } cmd_t;

endpackage

/* rtl/vtfp_front.sv */
`timescale 1ns / 1ps

module vtfp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_byte_in,
    input  logic                q_full,
    output logic                push,
    output vtfp_pkg::cmd_t      push_cmd
);
    import vtfp_pkg::*;

    logic [3:0] pos_reg, pos_next;
    logic [1:0] kind_reg, kind_next;
    logic [3:0] tail_pos;
    logic       accept;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign tail_pos = (kind_reg == KIND_COLOR) ? TAIL_POS_LONG : TAIL_POS_SHORT;

    always_comb begin
        logic [3:0] rel;
        rel           = pos_reg - POS_PAYLOAD;
        pos_next      = pos_reg;
        kind_next     = kind_reg;
        push          = 1'b0;
        push_cmd.op   = OP_STORE;
        push_cmd.idx  = rel[PAY_IDX_W-1:0];
        push_cmd.data = s_byte_in;
        push_cmd.kind = kind_reg;
        if (accept) begin
            if (pos_reg == POS_HEADER) begin
                if (s_byte_in == HDR_BYTE) begin
                    pos_next = POS_TYPE;
                end
            end else if (pos_reg == POS_TYPE) begin
                pos_next = POS_PAYLOAD;
                unique case (s_byte_in)
                    TYPE_DOT:   kind_next = KIND_DOT;
                    TYPE_CIRC:  kind_next = KIND_CIRC;
                    TYPE_COLOR: kind_next = KIND_COLOR;
                    default: begin
                        pos_next  = POS_HEADER;
                        kind_next = KIND_DOT;
                    end
                endcase
            end else if (kind_reg != KIND_DOT && kind_reg != KIND_CIRC
                         && kind_reg != KIND_COLOR) begin
                pos_next  = POS_HEADER;
                kind_next = KIND_DOT;
            end else if (pos_reg < tail_pos) begin
                push     = 1'b1;
                pos_next = pos_reg + 4'd1;
            end else begin
                // Tail position or beyond: the frame ends here either way.
                if (pos_reg == tail_pos && s_byte_in == TAIL_BYTE) begin
                    push        = 1'b1;
                    push_cmd.op = OP_EMIT;
                end
                pos_next  = POS_HEADER;
                kind_next = KIND_DOT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= POS_HEADER;
            kind_reg <= KIND_DOT;
        end else begin
            pos_reg  <= pos_next;
            kind_reg <= kind_next;
        end
    end

endmodule

/* rtl/vtfp_cmd_queue.sv */
`timescale 1ns / 1ps

module vtfp_cmd_queue #(
    parameter int DEPTH = vtfp_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  vtfp_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output vtfp_pkg::cmd_t q_cmd
);
    import vtfp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = slot_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (!push && do_pop) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/vtfp_back.sv */
`timescale 1ns / 1ps

module vtfp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  vtfp_pkg::cmd_t     q_cmd,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_frame_kind,
    output logic [7:0]         m_found_flag,
    output logic [7:0]         m_color_code,
    output logic [7:0]         m_shape_code,
    output logic signed [15:0] m_pos_x,
    output logic signed [15:0] m_pos_y
);
    import vtfp_pkg::*;

    logic [7:0]  payload_reg [PAY_DEPTH];
    logic        m_valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  flag_reg, color_reg, shape_reg;
    logic [15:0] x_reg, y_reg;
    logic        emit;

    assign pop  = q_valid && (q_cmd.op == OP_STORE || !m_valid_reg || m_ready);
    assign emit = pop && q_cmd.op == OP_EMIT;

    always_ff @(posedge aclk) begin
        if (pop && q_cmd.op == OP_STORE && q_cmd.idx < PAY_IDX_W'(PAY_DEPTH)) begin
            payload_reg[q_cmd.idx] <= q_cmd.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            kind_reg <= q_cmd.kind;
            flag_reg <= payload_reg[0];
            if (q_cmd.kind == KIND_COLOR) begin
                color_reg <= payload_reg[1];
                shape_reg <= payload_reg[2];
                x_reg     <= {payload_reg[3], payload_reg[4]};
                y_reg     <= {payload_reg[5], payload_reg[6]};
            end else begin
                color_reg <= 8'd0;
                shape_reg <= 8'd0;
                x_reg     <= {payload_reg[1], payload_reg[2]};
                y_reg     <= {payload_reg[3], payload_reg[4]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_kind = kind_reg;
    assign m_found_flag = flag_reg;
    assign m_color_code = color_reg;
    assign m_shape_code = shape_reg;
    assign m_pos_x      = signed'(x_reg);
    assign m_pos_y      = signed'(y_reg);

endmodule

/* rtl/vision_target_frame_parser.sv */
`timescale 1ns / 1ps
// Front parser, command queue and result stage run every cycle; a tail byte's emit command passes
// through the queue and is registered in the output stage when free. Throughput: one byte per
// cycle unless the queue is full; its depth sets how long the output may stall before input waits.
// Reset: synchronous active-low aresetn returns the parser to hunting for a header and empties
// the queue and the output stage; stored payload bytes are not cleared.

module vision_target_frame_parser #(
    parameter int QUEUE_DEPTH = vtfp_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_byte_in,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_frame_kind,
    output logic [7:0]         m_found_flag,
    output logic [7:0]         m_color_code,
    output logic [7:0]         m_shape_code,
    output logic signed [15:0] m_pos_x,
    output logic signed [15:0] m_pos_y
);
    import vtfp_pkg::*;

    // The front tracks the frame position and turns each payload byte into a store
    // command and each good tail into an emit command. Header, type and dropped
    // bytes produce no command at all.
    logic push, q_full, pop, q_valid;
    cmd_t push_cmd, q_cmd;

    vtfp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_byte_in (s_byte_in),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Commands stay in order, so every store of a frame lands before its emit.
    vtfp_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // The back keeps the payload bytes and builds the result item in its output
    // register; stores drain even while a result waits to be taken.
    vtfp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_kind (m_frame_kind),
        .m_found_flag (m_found_flag),
        .m_color_code (m_color_code),
        .m_shape_code (m_shape_code),
        .m_pos_x      (m_pos_x),
        .m_pos_y      (m_pos_y)
    );

endmodule

/* rtl/vtfp_checker.sv */
`timescale 1ns / 1ps

module vtfp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_frame_kind,
    input logic [7:0]  m_found_flag,
    input logic [7:0]  m_color_code,
    input logic [7:0]  m_shape_code,
    input logic [15:0] m_pos_x,
    input logic [15:0] m_pos_y
);
    import vtfp_pkg::*;

    // Reset empties the output stage.
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Only the three frame kinds can be reported.
    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_kind == KIND_DOT || m_frame_kind == KIND_CIRC
                     || m_frame_kind == KIND_COLOR))
        else $error("illegal frame kind");

    // Dot and circle frames carry no color or shape bytes.
    a_short_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_kind != KIND_COLOR |-> m_color_code == 8'd0
                                                  && m_shape_code == 8'd0)
        else $error("color or shape set on a short frame");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_kind) && $stable(m_found_flag)
                                && $stable(m_pos_x) && $stable(m_pos_y))
        else $error("stalled result changed");

endmodule

bind vision_target_frame_parser vtfp_checker u_vtfp_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_frame_kind (m_frame_kind),
    .m_found_flag (m_found_flag),
    .m_color_code (m_color_code),
    .m_shape_code (m_shape_code),
    .m_pos_x      (m_pos_x),
    .m_pos_y      (m_pos_y)
);
